/* src/irst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irst_pkg: shared codes and stream widths for the integer range set table
// Operation and status codes and the packed widths of the stream payloads.
// ----------------------------------------------------------------------------
package irst_pkg;

    localparam int FIELD_W     = 32;
    localparam int COUNT_OUT_W = 7;
    localparam int TOTAL_OUT_W = 33;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 112;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_NONE  = 2'd2;
    localparam logic [1:0] STATUS_EMPTY = 2'd3;

endpackage

/* src/integer_range_set_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_range_set_table: set of integers held as sorted disjoint ranges
// Insert, remove and pop requests edit a table of non-adjacent inclusive
// ranges held in one synchronous memory; every request returns one reply.
//
//  Channel   Direction  Contents
//  s_axis    in         op, value_low, value_high
//  m_axis    out        status, popped_value, first_member, set_empty,
//                       range_count, member_total
//
// A request scans entries, moves entries, writes up to two new ranges and
// passes the accept, calculate, settle and reply states: the memory port
// moves one entry per cycle. The scan stops where the shift starts, so reads
// plus moves never exceed MAX_RANGES + 1.
// Reset empties the set at once; no clearing pass is needed.
// A new request is taken while the previous reply still waits on m_axis.
// ----------------------------------------------------------------------------
module integer_range_set_table
    import irst_pkg::*;
#(
    parameter int MAX_RANGES = 64,
    parameter int VALUE_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // op[1:0], value_low[33:2], value_high[65:34], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // status[1:0], popped_value[33:2], first_member[65:34], set_empty[66],
    // range_count[73:67], member_total[106:74], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int VW = VALUE_BITS;
    localparam int IW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_CALC   = 4'd2;
    localparam logic [3:0] S_SHIFT  = 4'd3;
    localparam logic [3:0] S_WR0    = 4'd4;
    localparam logic [3:0] S_WR1    = 4'd5;
    localparam logic [3:0] S_FIN    = 4'd6;
    localparam logic [3:0] S_RESULT = 4'd7;

    // Each memory word holds {high, low} of one range.
    logic [2*VW-1:0] range_mem [MAX_RANGES];
    logic [2*VW-1:0] mem_rd_reg;
    logic            wr_en;
    logic [IW-1:0]   waddr;
    logic [2*VW-1:0] wdata;

    logic [3:0]      state_reg, state_next;
    logic [1:0]      op_reg, op_next;
    logic [VW-1:0]   a_reg, a_next, b_reg, b_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   f_reg, f_next, l_reg, l_next;
    logic [VW-1:0]   first_lo_reg, first_lo_next, last_hi_reg, last_hi_next;
    logic [VW:0]     sum_reg, sum_next;
    logic [CW-1:0]   used_reg, used_next;
    logic [VW:0]     members_reg, members_next;
    logic [1:0]      status_reg, status_next;
    logic [VW-1:0]   taken_reg, taken_next;
    logic [1:0]      n_reg, n_next;
    logic [VW-1:0]   new_lo_reg [2];
    logic [VW-1:0]   new_lo_next [2];
    logic [VW-1:0]   new_hi_reg [2];
    logic [VW-1:0]   new_hi_next [2];
    logic            shift_up_reg, shift_up_next;
    logic [CW-1:0]   dist_reg, dist_next;
    logic [CW-1:0]   last_reg, last_next;
    logic            m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    logic [VW-1:0]   in_low, in_high, ent_lo, ent_hi;
    logic            is_ins, fc, lc;
    logic [VW:0]     ent_size;

    assign ent_lo   = mem_rd_reg[VW-1:0];
    assign ent_hi   = mem_rd_reg[2*VW-1:VW];
    assign ent_size = {1'b0, ent_hi} - {1'b0, ent_lo} + 1'b1;
    assign is_ins   = (op_reg == OP_INSERT);
    // Insert also takes in ranges that merely touch the bound range.
    assign fc = is_ins ? (({1'b0, ent_hi} + 1'b1) < {1'b0, a_reg}) : (ent_hi < a_reg);
    assign lc = {1'b0, ent_lo} <= ({1'b0, b_reg} + (is_ins ? 1'b1 : 1'b0));

    assign in_low  = VW'(s_axis_tdata[FIELD_W+1:2]);
    assign in_high = VW'(s_axis_tdata[2*FIELD_W+1:FIELD_W+2]);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            range_mem[waddr] <= wdata;
        end
        mem_rd_reg <= range_mem[idx_next[IW-1:0]];
    end

    always_comb
    begin
        logic [CW-1:0] span;
        logic          c1, c2, go;
        logic [1:0]    n;
        logic [CW:0]   grown;
        state_next    = state_reg;
        op_next       = op_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        idx_next      = idx_reg;
        f_next        = f_reg;
        l_next        = l_reg;
        first_lo_next = first_lo_reg;
        last_hi_next  = last_hi_reg;
        sum_next      = sum_reg;
        used_next     = used_reg;
        members_next  = members_reg;
        status_next   = status_reg;
        taken_next    = taken_reg;
        n_next        = n_reg;
        new_lo_next   = new_lo_reg;
        new_hi_next   = new_hi_reg;
        shift_up_next = shift_up_reg;
        dist_next     = dist_reg;
        last_next     = last_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        wr_en         = 1'b0;
        waddr         = f_reg[IW-1:0];
        wdata         = {new_hi_reg[0], new_lo_reg[0]};
        span          = l_reg - f_reg;
        c1            = 1'b0;
        c2            = 1'b0;
        go            = 1'b0;
        n             = 2'd0;
        grown         = '0;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                if (s_axis_tvalid)
                begin
                    op_next     = s_axis_tdata[1:0];
                    a_next      = (in_high < in_low) ? in_high : in_low;
                    b_next      = (in_high < in_low) ? in_low : in_high;
                    f_next      = '0;
                    sum_next    = '0;
                    status_next = STATUS_OK;
                    taken_next  = '0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                priority if (op_reg == OP_POP)
                begin
                    if (used_reg == '0)
                    begin
                        status_next = STATUS_EMPTY;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        f_next        = '0;
                        l_next        = CW'(1);
                        first_lo_next = ent_lo;
                        last_hi_next  = ent_hi;
                        sum_next      = ent_size;
                        state_next    = S_CALC;
                    end
                end
                else if (op_reg == OP_NOP)
                begin
                    state_next = S_FIN;
                end
                else if (idx_reg == used_reg || !lc)
                begin
                    l_next     = idx_reg;
                    state_next = S_CALC;
                end
                else
                begin
                    if (fc)
                    begin
                        f_next = idx_reg + 1'b1;
                    end
                    else
                    begin
                        if (idx_reg == f_reg)
                        begin
                            first_lo_next = ent_lo;
                        end
                        last_hi_next = ent_hi;
                        sum_next     = sum_reg + ent_size;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_CALC:
            begin
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        n = 2'd1;
                        if (span == '0)
                        begin
                            new_lo_next[0] = a_reg;
                            new_hi_next[0] = b_reg;
                            go = (used_reg != CW'(MAX_RANGES));
                            if (!go)
                            begin
                                status_next = STATUS_FULL;
                            end
                        end
                        else
                        begin
                            new_lo_next[0] = (first_lo_reg < a_reg) ? first_lo_reg : a_reg;
                            new_hi_next[0] = (last_hi_reg > b_reg) ? last_hi_reg : b_reg;
                            go = 1'b1;
                        end
                    end
                    OP_REMOVE:
                    begin
                        c1 = first_lo_reg < a_reg;
                        c2 = last_hi_reg > b_reg;
                        n  = {1'b0, c1} + {1'b0, c2};
                        new_lo_next[0] = c1 ? first_lo_reg : b_reg + 1'b1;
                        new_hi_next[0] = c1 ? a_reg - 1'b1 : last_hi_reg;
                        new_lo_next[1] = b_reg + 1'b1;
                        new_hi_next[1] = last_hi_reg;
                        grown = {1'b0, used_reg} - {1'b0, span} + (CW+1)'(n);
                        if (span == '0)
                        begin
                            status_next = STATUS_NONE;
                        end
                        else if (grown > (CW+1)'(MAX_RANGES))
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            go = 1'b1;
                        end
                    end
                    default:
                    begin
                        // Pop: drop the first range or lift its low bound.
                        n = (first_lo_reg == last_hi_reg) ? 2'd0 : 2'd1;
                        new_lo_next[0] = first_lo_reg + 1'b1;
                        new_hi_next[0] = last_hi_reg;
                        taken_next     = first_lo_reg;
                        go             = 1'b1;
                    end
                endcase
                n_next = n;
                if (!go)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    members_next = members_reg - sum_reg;
                    used_next    = used_reg - span + CW'(n);
                    last_next    = used_reg - 1'b1;
                    dist_next    = span - CW'(n);
                    priority if (CW'(n) > span && used_reg > l_reg)
                    begin
                        shift_up_next = 1'b1;
                        idx_next      = used_reg - 1'b1;
                        state_next    = S_SHIFT;
                    end
                    else if (CW'(n) < span && used_reg > l_reg)
                    begin
                        shift_up_next = 1'b0;
                        idx_next      = l_reg;
                        state_next    = S_SHIFT;
                    end
                    else
                    begin
                        state_next = (n != 2'd0) ? S_WR0 : S_FIN;
                    end
                end
            end
            S_SHIFT:
            begin
                wr_en = 1'b1;
                wdata = mem_rd_reg;
                waddr = shift_up_reg ? IW'(idx_reg + 1'b1) : IW'(idx_reg - dist_reg);
                idx_next = shift_up_reg ? idx_reg - 1'b1 : idx_reg + 1'b1;
                if (shift_up_reg ? (idx_reg == l_reg) : (idx_reg == last_reg))
                begin
                    state_next = (n_reg != 2'd0) ? S_WR0 : S_FIN;
                end
            end
            S_WR0:
            begin
                wr_en        = 1'b1;
                members_next = members_reg
                             + ({1'b0, new_hi_reg[0]} - {1'b0, new_lo_reg[0]} + 1'b1);
                state_next   = (n_reg == 2'd2) ? S_WR1 : S_FIN;
            end
            S_WR1:
            begin
                wr_en        = 1'b1;
                waddr        = IW'(f_reg + 1'b1);
                wdata        = {new_hi_reg[1], new_lo_reg[1]};
                members_next = members_reg
                             + ({1'b0, new_hi_reg[1]} - {1'b0, new_lo_reg[1]} + 1'b1);
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                // Read entry zero only after the last write has landed.
                idx_next   = '0;
                state_next = S_RESULT;
            end
            default:
            begin
                idx_next = '0;
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {
                        (OUT_TDATA_W - 107)'(0),
                        TOTAL_OUT_W'(members_reg),
                        COUNT_OUT_W'(used_reg),
                        (used_reg == '0),
                        (used_reg == '0) ? FIELD_W'(0) : FIELD_W'(ent_lo),
                        FIELD_W'(taken_reg),
                        status_reg
                    };
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            used_reg    <= '0;
            members_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            used_reg    <= used_next;
            members_reg <= members_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        f_reg         <= f_next;
        l_reg         <= l_next;
        first_lo_reg  <= first_lo_next;
        last_hi_reg   <= last_hi_next;
        sum_reg       <= sum_next;
        status_reg    <= status_next;
        taken_reg     <= taken_next;
        n_reg         <= n_next;
        new_lo_reg    <= new_lo_next;
        new_hi_reg    <= new_hi_next;
        shift_up_reg  <= shift_up_next;
        dist_reg      <= dist_next;
        last_reg      <= last_next;
        m_data_reg    <= m_data_next;
    end

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(MAX_RANGES))
        else $error("range count beyond table depth");

    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg == '0) |-> (members_reg == '0))
        else $error("members held with no ranges stored");

    a_reply_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (m_data_reg[66] == (m_data_reg[73:67] == '0)))
        else $error("set_empty disagrees with range_count");

    a_shift_no_write_zero_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT) |-> $past(state_reg) == S_FIN || $past(state_reg) == S_RESULT)
        else $error("reply formed before entry zero was reread");

endmodule
